FILE: hw/rtl/cwss_pkg.sv
package cwss_pkg;

    // fixed point format of the data operands; the site count is an integer
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 8;
    localparam int ACC_W     = 64;
    localparam int PROD_W    = 2 * DATA_W;
    // a floored product keeps this many significant bits
    localparam int FL_W      = PROD_W - FRAC_BITS;

    // microprogram geometry
    localparam int STEP_W    = 4;
    localparam int ROM_DEPTH = 2 ** STEP_W;
    localparam logic [STEP_W-1:0] STEP_IDLE = '0;

    // multiplier operand a
    typedef enum logic [1:0] {
        A_SR,
        A_SI,
        A_RE,
        A_IM
    } t_a_sel;

    // multiplier operand b
    typedef enum logic [1:0] {
        B_CR,
        B_CI,
        B_W,
        B_CNT
    } t_b_sel;

    // what the datapath does with the registered product
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TMP,
        OP_PR,
        OP_PI,
        OP_QR,
        OP_QI,
        OP_ACC_RE,
        OP_ACC_IM
    } t_dp_op;

    // how the step counter moves
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_END
    } t_jmp;

    typedef struct packed {
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_dp_op op;
        t_jmp   jmp;
    } t_ctrl_word;

    // sequencer to datapath
    typedef struct packed {
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_dp_op op;
        logic   load_in;
        logic   emit;
    } t_dp_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_stat;

    // one multiply per step, product is registered and used one step later
    // the final step repeats the count product so a stalled final step keeps it
    localparam t_ctrl_word CW_ROM [ROM_DEPTH] = '{
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_WAIT_IN},
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_NEXT},
        '{a_sel: A_SI, b_sel: B_CI,  op: OP_TMP,    jmp: JMP_NEXT},
        '{a_sel: A_SR, b_sel: B_CI,  op: OP_PR,     jmp: JMP_NEXT},
        '{a_sel: A_SI, b_sel: B_CR,  op: OP_TMP,    jmp: JMP_NEXT},
        '{a_sel: A_RE, b_sel: B_W,   op: OP_PI,     jmp: JMP_NEXT},
        '{a_sel: A_IM, b_sel: B_W,   op: OP_QR,     jmp: JMP_NEXT},
        '{a_sel: A_RE, b_sel: B_CNT, op: OP_QI,     jmp: JMP_NEXT},
        '{a_sel: A_IM, b_sel: B_CNT, op: OP_ACC_RE, jmp: JMP_NEXT},
        '{a_sel: A_IM, b_sel: B_CNT, op: OP_ACC_IM, jmp: JMP_END},
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_END},
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_END},
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_END},
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_END},
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_END},
        '{a_sel: A_SR, b_sel: B_CR,  op: OP_NONE,   jmp: JMP_END}
    };

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                         input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/cwss_in_if.sv
interface cwss_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cwss_pkg::DATA_W-1:0]     solution_re;
    logic signed [cwss_pkg::DATA_W-1:0]     solution_im;
    logic signed [cwss_pkg::DATA_W-1:0]     chi_re;
    logic signed [cwss_pkg::DATA_W-1:0]     chi_im;
    logic signed [cwss_pkg::DATA_W-1:0]     density_weight;
    logic        [cwss_pkg::CNT_W-1:0]      site_count;
    logic                                   last_term;

    modport source (
        output valid, solution_re, solution_im, chi_re, chi_im,
               density_weight, site_count, last_term,
        input  ready
    );
    modport sink (
        input  valid, solution_re, solution_im, chi_re, chi_im,
               density_weight, site_count, last_term,
        output ready
    );
endinterface

FILE: hw/rtl/cwss_out_if.sv
interface cwss_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cwss_pkg::DATA_W-1:0] sum_re;
    logic signed [cwss_pkg::DATA_W-1:0] sum_im;

    modport source (
        output valid, sum_re, sum_im,
        input  ready
    );
    modport sink (
        input  valid, sum_re, sum_im,
        output ready
    );
endinterface

FILE: hw/rtl/cwss_seq.sv
module cwss_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cwss_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output cwss_pkg::t_dp_ctl   o_ctl
);

    logic [cwss_pkg::STEP_W-1:0] r_step;
    logic [cwss_pkg::STEP_W-1:0] n_step;
    cwss_pkg::t_ctrl_word        cw;
    logic                        advance;

    assign cw = cwss_pkg::CW_ROM[r_step];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= cwss_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_in_ready    = 1'b0;
        advance       = 1'b1;
        n_step        = r_step;
        o_ctl.a_sel   = cw.a_sel;
        o_ctl.b_sel   = cw.b_sel;
        o_ctl.load_in = 1'b0;
        o_ctl.emit    = 1'b0;
        case (cw.jmp)
            cwss_pkg::JMP_WAIT_IN: begin
                o_in_ready    = 1'b1;
                o_ctl.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_step = r_step + cwss_pkg::STEP_W'(1);
                end
            end
            cwss_pkg::JMP_END: begin
                // hold a last term while the result slot is still occupied
                advance = !(i_stat.last && !i_stat.out_free);
                if (advance) begin
                    n_step     = cwss_pkg::STEP_IDLE;
                    o_ctl.emit = i_stat.last;
                end
            end
            default: begin
                n_step = r_step + cwss_pkg::STEP_W'(1);
            end
        endcase
        o_ctl.op = advance ? cw.op : cwss_pkg::OP_NONE;
    end

endmodule

FILE: hw/rtl/cwss_dp.sv
module cwss_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cwss_pkg::t_dp_ctl                   i_ctl,
    input  logic signed [cwss_pkg::DATA_W-1:0]  i_solution_re,
    input  logic signed [cwss_pkg::DATA_W-1:0]  i_solution_im,
    input  logic signed [cwss_pkg::DATA_W-1:0]  i_chi_re,
    input  logic signed [cwss_pkg::DATA_W-1:0]  i_chi_im,
    input  logic signed [cwss_pkg::DATA_W-1:0]  i_density_weight,
    input  logic        [cwss_pkg::CNT_W-1:0]   i_site_count,
    input  logic                                i_last_term,
    input  logic                                i_out_ready,
    output cwss_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    output logic signed [cwss_pkg::DATA_W-1:0]  o_sum_re,
    output logic signed [cwss_pkg::DATA_W-1:0]  o_sum_im
);

    localparam int DW = cwss_pkg::DATA_W;
    localparam int FW = cwss_pkg::FL_W;
    localparam int AW = cwss_pkg::ACC_W;
    localparam int PW = cwss_pkg::PROD_W;

    // captured item
    logic signed [DW-1:0]             r_sr, r_si, r_cr, r_ci, r_w;
    logic        [cwss_pkg::CNT_W-1:0] r_cnt;
    logic                              r_last;

    // working registers
    logic signed [cwss_pkg::PROD_W-1:0] r_prod;
    logic signed [FW-1:0]               r_tmp;
    logic signed [DW-1:0]               r_re;
    logic signed [DW-1:0]               r_im;
    logic signed [AW-1:0]               r_acc_re;
    logic signed [AW-1:0]               r_acc_im;
    logic                               r_out_valid;
    logic signed [DW-1:0]               r_sum_re;
    logic signed [DW-1:0]               r_sum_im;

    logic signed [DW-1:0]               mul_a;
    logic signed [DW-1:0]               mul_b;
    logic signed [cwss_pkg::PROD_W-1:0] prod_sh;
    logic signed [FW-1:0]               fl_p;
    logic signed [FW:0]                 diff;
    logic signed [FW:0]                 summ;
    logic signed [AW-1:0]               n_acc_re;
    logic signed [AW-1:0]               n_acc_im;

    always_comb begin
        case (i_ctl.a_sel)
            cwss_pkg::A_SR: mul_a = r_sr;
            cwss_pkg::A_SI: mul_a = r_si;
            cwss_pkg::A_RE: mul_a = r_re;
            cwss_pkg::A_IM: mul_a = r_im;
            default:        mul_a = r_sr;
        endcase
        case (i_ctl.b_sel)
            cwss_pkg::B_CR:  mul_b = r_cr;
            cwss_pkg::B_CI:  mul_b = r_ci;
            cwss_pkg::B_W:   mul_b = r_w;
            cwss_pkg::B_CNT: mul_b = $signed({{(DW-cwss_pkg::CNT_W){1'b0}}, r_cnt});
            default:         mul_b = r_cr;
        endcase
    end

    // floor of product / 2^frac
    assign prod_sh  = r_prod >>> cwss_pkg::FRAC_BITS;
    assign fl_p     = prod_sh[FW-1:0];
    assign diff     = (FW+1)'(r_tmp) - (FW+1)'(fl_p);
    assign summ     = (FW+1)'(r_tmp) + (FW+1)'(fl_p);
    assign n_acc_re = cwss_pkg::sat_add64(r_acc_re, r_prod);
    assign n_acc_im = cwss_pkg::sat_add64(r_acc_im, r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_sr   <= i_solution_re;
            r_si   <= i_solution_im;
            r_cr   <= i_chi_re;
            r_ci   <= i_chi_im;
            r_w    <= i_density_weight;
            r_cnt  <= i_site_count;
            r_last <= i_last_term;
        end
        r_prod <= PW'(mul_a) * PW'(mul_b);
        case (i_ctl.op)
            cwss_pkg::OP_TMP: r_tmp <= fl_p;
            cwss_pkg::OP_PR:  r_re  <= cwss_pkg::sat32(AW'(diff));
            cwss_pkg::OP_PI:  r_im  <= cwss_pkg::sat32(AW'(summ));
            cwss_pkg::OP_QR:  r_re  <= cwss_pkg::sat32(AW'(fl_p));
            cwss_pkg::OP_QI:  r_im  <= cwss_pkg::sat32(AW'(fl_p));
            default: ;
        endcase
        if (i_ctl.emit) begin
            r_sum_re <= cwss_pkg::sat32(r_acc_re);
            r_sum_im <= cwss_pkg::sat32(n_acc_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.op == cwss_pkg::OP_ACC_RE) begin
                r_acc_re <= n_acc_re;
            end
            if (i_ctl.op == cwss_pkg::OP_ACC_IM) begin
                r_acc_im <= n_acc_im;
            end
            if (i_ctl.emit) begin
                r_acc_re    <= '0;
                r_acc_im    <= '0;
                r_out_valid <= 1'b1;
            end
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_sum_re        = r_sum_re;
    assign o_sum_im        = r_sum_im;

endmodule

FILE: hw/rtl/complex_weighted_site_sum_top.sv
// complex weighted site sum
// i_in takes one source-site term per item: solution and chi as complex
// Q16.16 values, a real density weight and an integer site count, plus a
// flag that marks the last term of a sum. o_out gives one item per sum,
// the saturated complex total, after the item that carries the last flag.
// valid/ready on both channels, an item moves when both are high.
// one shared 32x32 multiplier does the four complex partial products and
// the two weight and two count scalings, one per step of a ten-step
// microprogram, so an item runs through all its steps before the
// next item can be taken; ready is high only in the idle step.
// o_out.valid is registered and is set as the last term's final step emits.
// the result sits in an output register; if the receiver stalls, the next
// sum's terms are still accepted and only its last term waits in its
// final step until the register is free.
// synchronous active-low reset clears the step counter, the accumulators
// and the output valid; the block can take an item in the first cycle
// after reset is released.
module complex_weighted_site_sum_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cwss_in_if.sink i_in,
    cwss_out_if.source o_out
);

    cwss_pkg::t_dp_ctl  ctl;
    cwss_pkg::t_dp_stat stat;

    // step counter and microcode table
    cwss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_ctl      (ctl)
    );

    // shared multiplier, saturating stages and accumulators
    cwss_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_solution_re    (i_in.solution_re),
        .i_solution_im    (i_in.solution_im),
        .i_chi_re         (i_in.chi_re),
        .i_chi_im         (i_in.chi_im),
        .i_density_weight (i_in.density_weight),
        .i_site_count     (i_in.site_count),
        .i_last_term      (i_in.last_term),
        .i_out_ready      (o_out.ready),
        .o_stat           (stat),
        .o_out_valid      (o_out.valid),
        .o_sum_re         (o_out.sum_re),
        .o_sum_im         (o_out.sum_im)
    );

endmodule
